FILE: design/smq_pkg.sv
// ---------------------------------------------------------------------------
// smq_pkg: shared types and constants of the stepper move queue
// Word layouts, operation codes and the command and status bundles that
// pass between the controller and the datapath.
// ---------------------------------------------------------------------------
package smq_pkg;

	localparam int QUEUE_DEPTH        = 16;
	localparam int MAX_STEPS_PER_TICK = 16;

	localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int LEVEL_OUT_W = 5;
	localparam int NSTEP_W     = $clog2(MAX_STEPS_PER_TICK + 1);

	localparam logic [QIDX_W-1:0]  QIDX_LAST  = QIDX_W'(QUEUE_DEPTH - 1);
	localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(QUEUE_DEPTH);
	localparam logic [NSTEP_W-1:0] STEP_CAP   = NSTEP_W'(MAX_STEPS_PER_TICK);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_TICK  = 2'd1,
		OP_FLUSH = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [31:0]        step_interval;
		logic [15:0]        step_total;
		logic signed [15:0] interval_add;
		logic               move_reverse;
		logic [31:0]        now_time;
	} in_word_t;

	typedef struct packed {
		logic                     step_pulse;
		logic                     step_reverse;
		logic signed [31:0]       position_steps;
		logic [LEVEL_OUT_W-1:0]   queue_level;
		logic                     push_rejected;
		logic                     moving;
		logic                     last;
	} out_word_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;      // latch tick time and push status
		logic push;        // store a move
		logic flush;       // empty queue, end active move
		logic step;        // issue one step
		logic emit_mid;    // output the previous step word, not final
		logic fetch;       // pop next move if the active one is exhausted
		logic emit_last;   // output the final word of the item
		logic final_pulse; // the final word is a step word
	} smq_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic step_ok;     // steps left and due time reached
	} smq_status_t;

endpackage

FILE: design/smq_datapath.sv
// ---------------------------------------------------------------------------
// smq_datapath: move store, active move registers and output register
// Holds the ring of queued moves, the active move, the due time and the
// position, and forms every output word.
// ---------------------------------------------------------------------------
module smq_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smq_pkg::in_word_t    request,
	input  smq_pkg::smq_cmd_t    cmd,
	output smq_pkg::smq_status_t status,
	output logic                 result_strobe,
	output smq_pkg::out_word_t   result
);

	logic [31:0] interval_mem [smq_pkg::QUEUE_DEPTH];
	logic [32:0] cad_mem [smq_pkg::QUEUE_DEPTH];
	logic [31:0] rd_interval_q;
	logic [32:0] rd_cad_q;

	logic [smq_pkg::QIDX_W-1:0]  wr_idx_q, rd_idx_q;
	logic [smq_pkg::LEVEL_W-1:0] level_q;
	logic [31:0]                 interval_q;
	logic [15:0]                 count_q;
	logic [15:0]                 add_q;
	logic                        reverse_q;
	logic [31:0]                 due_q;
	logic signed [31:0]          position_q;
	logic [31:0]                 now_q;
	logic                        rej_q;
	logic                        step_rev_q;
	logic                        strobe_q;
	smq_pkg::out_word_t          result_q;

	logic                        full;
	logic [31:0]                 since_due;
	logic [31:0]                 add_ext;
	logic [31:0]                 level_ext;
	logic [smq_pkg::LEVEL_OUT_W-1:0] level_out;

	function automatic logic [smq_pkg::QIDX_W-1:0] wrap_next(
		input logic [smq_pkg::QIDX_W-1:0] idx);
		logic [smq_pkg::QIDX_W-1:0] nxt;
		nxt = (idx == smq_pkg::QIDX_LAST) ? '0 : idx + 1'b1;
		return nxt;
	endfunction

	assign full      = (level_q == smq_pkg::LEVEL_FULL);
	assign since_due = now_q - due_q;
	assign add_ext   = {{16{add_q[15]}}, add_q};
	assign level_ext = {{(32-smq_pkg::LEVEL_W){1'b0}}, level_q};
	assign level_out = level_ext[smq_pkg::LEVEL_OUT_W-1:0];

	assign status.step_ok = (count_q != 16'd0) && !since_due[31];

	// Move store: no reset, entries are read only after being written.
	always_ff @(posedge clk) begin
		if (cmd.push && !full) begin
			interval_mem[wr_idx_q] <= request.step_interval;
			cad_mem[wr_idx_q]      <= {request.move_reverse, request.interval_add,
				request.step_total};
		end
		rd_interval_q <= interval_mem[rd_idx_q];
		rd_cad_q      <= cad_mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q   <= '0;
			rd_idx_q   <= '0;
			level_q    <= '0;
			interval_q <= '1;
			count_q    <= '0;
			add_q      <= '0;
			reverse_q  <= 1'b0;
			due_q      <= '0;
			position_q <= '0;
			rej_q      <= 1'b0;
			step_rev_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_mid || cmd.emit_last;
			if (cmd.accept) begin
				rej_q <= cmd.push && full;
			end
			if (cmd.push && !full) begin
				wr_idx_q <= wrap_next(wr_idx_q);
				level_q  <= level_q + 1'b1;
			end
			if (cmd.flush) begin
				level_q    <= '0;
				rd_idx_q   <= wr_idx_q;
				interval_q <= '1;
				count_q    <= '0;
				add_q      <= '0;
				reverse_q  <= 1'b0;
			end
			if (cmd.step) begin
				position_q <= reverse_q ? position_q - 32'sd1 : position_q + 32'sd1;
				due_q      <= due_q + interval_q;
				interval_q <= interval_q + add_ext;
				count_q    <= count_q - 16'd1;
				step_rev_q <= reverse_q;
			end
			if (cmd.fetch && count_q == 16'd0) begin
				if (level_q != '0) begin
					interval_q <= rd_interval_q;
					count_q    <= rd_cad_q[15:0];
					add_q      <= rd_cad_q[31:16];
					reverse_q  <= rd_cad_q[32];
					level_q    <= level_q - 1'b1;
					rd_idx_q   <= wrap_next(rd_idx_q);
				end else begin
					interval_q <= '1;
					count_q    <= '0;
					add_q      <= '0;
					reverse_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			now_q <= request.now_time;
		end
		if (cmd.emit_mid) begin
			// The previous step left steps behind, otherwise no new step runs.
			result_q.step_pulse     <= 1'b1;
			result_q.step_reverse   <= step_rev_q;
			result_q.position_steps <= position_q;
			result_q.queue_level    <= level_out;
			result_q.push_rejected  <= 1'b0;
			result_q.moving         <= 1'b1;
			result_q.last           <= 1'b0;
		end else if (cmd.emit_last) begin
			result_q.step_pulse     <= cmd.final_pulse;
			result_q.step_reverse   <= cmd.final_pulse && step_rev_q;
			result_q.position_steps <= position_q;
			result_q.queue_level    <= level_out;
			result_q.push_rejected  <= rej_q;
			result_q.moving         <= (count_q != 16'd0);
			result_q.last           <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

FILE: design/smq_ctrl.sv
// ---------------------------------------------------------------------------
// smq_ctrl: sequencer of the stepper move queue
// Decodes each accepted word and steps the datapath through stepping,
// move fetch and the final response.
// ---------------------------------------------------------------------------
module smq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           operation,
	input  smq_pkg::smq_status_t status,
	output logic                 busy,
	output smq_pkg::smq_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_TICK  = 4'b0010,
		S_FETCH = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t                      state_q, state_d;
	logic [smq_pkg::NSTEP_W-1:0] nsteps_q;
	logic                        accept;
	logic                        do_step;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign do_step = (state_q == S_TICK) && status.step_ok && (nsteps_q < smq_pkg::STEP_CAP);

	always_comb begin
		cmd             = '0;
		cmd.accept      = accept;
		cmd.push        = accept && (operation == smq_pkg::OP_PUSH);
		cmd.flush       = accept && (operation == smq_pkg::OP_FLUSH);
		cmd.step        = do_step;
		cmd.emit_mid    = do_step && (nsteps_q != '0);
		cmd.fetch       = (state_q == S_FETCH);
		cmd.emit_last   = (state_q == S_RESP);
		cmd.final_pulse = (nsteps_q != '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (operation == smq_pkg::OP_TICK) ? S_TICK : S_RESP;
				end
			end
			S_TICK: begin
				if (!do_step) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: state_d = S_RESP;
			S_RESP:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			nsteps_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				nsteps_q <= '0;
			end else if (do_step) begin
				nsteps_q <= nsteps_q + 1'b1;
			end
		end
	end

endmodule

FILE: design/stepper_move_queue_step_timer.sv
// ---------------------------------------------------------------------------
// stepper_move_queue_step_timer: step generator behind a ring queue of moves
// Queues moves, issues due steps on each time tick and pops the next move
// when the active one is exhausted.
// ---------------------------------------------------------------------------
// Usage: a word on request is taken at a rising edge where start is high and
// busy is low. Its operation field selects push move, time tick or flush;
// any other code only answers. Every word yields one or more result words on
// result, each shown for exactly one cycle with result_strobe high; the final
// word of the request has last set. The receiver cannot stall this port, so
// no result word is ever held back.
// Sequence: push, flush and unknown codes give a single result, and busy
// drops together with that result. A tick issues its steps (at most
// MAX_STEPS_PER_TICK) one at a time through the shared add and compare
// datapath, then sees that no further step runs, does the move fetch from
// the registered queue read port and gives the response.
// Step words come out one per cycle while stepping continues.
// Reset: arst_n clears the queue indices, the level, the position and the due
// time, and idles the active move; stored moves are not cleared.
// ---------------------------------------------------------------------------
module stepper_move_queue_step_timer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  smq_pkg::in_word_t  request,
	output logic               result_strobe,
	output smq_pkg::out_word_t result
);

	smq_pkg::smq_cmd_t    cmd;
	smq_pkg::smq_status_t status;

	// The sequencer decides, per cycle, which datapath action runs.
	smq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (request.operation),
		.status    (status),
		.busy      (busy),
		.cmd       (cmd)
	);

	// The datapath holds all move state and the registered output word.
	smq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.request       (request),
		.cmd           (cmd),
		.status        (status),
		.result_strobe (result_strobe),
		.result        (result)
	);

	// An accepted word always keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting a word");

	// The final word of a request is never directly followed by another word.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.last |=> !result_strobe)
		else $error("result word right after a final word");

	// A word that carries no step is always the only and final one.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.step_pulse |-> result.last)
		else $error("non-step word not marked final");

	// A rejected push answers with a single plain word.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && result.push_rejected |-> result.last && !result.step_pulse)
		else $error("rejected push word malformed");

endmodule
